// ===== rtl/core/spd_pkg.sv =====
// Shared types and constants of the serial packet deframer.
package spd_pkg;

    localparam int DataW = 8;
    localparam int IndexW = 7;
    localparam int QueueDepth = 2;

    // Hard ceiling on the accepted payload length.
    localparam logic [DataW-1:0] PayloadMax = 8'd128;

    localparam logic [DataW-1:0] SyncFirstReset = 8'h93;
    localparam logic [DataW-1:0] SyncSecondReset = 8'hE0;
    localparam logic [DataW-1:0] MaxPayloadReset = 8'd128;

    // Configuration register indexes.
    localparam logic [1:0] CfgSyncFirst = 2'd0;
    localparam logic [1:0] CfgSyncSecond = 2'd1;
    localparam logic [1:0] CfgMaxPayload = 2'd2;

    // Result status codes.
    localparam logic [2:0] StDone = 3'd0;
    localparam logic [2:0] StBusy = 3'd1;
    localparam logic [2:0] StSync0 = 3'd2;
    localparam logic [2:0] StSync1 = 3'd3;
    localparam logic [2:0] StLong = 3'd4;
    localparam logic [2:0] StCheck = 3'd5;

    // Output stream packing.
    localparam int OutDataW = 40;
    localparam int OutUserW = 4;

    typedef enum logic [2:0] {
        F_SYNC0,
        F_SYNC1,
        F_IDENT,
        F_KIND,
        F_LEN,
        F_PAYLOAD,
        F_CHECK0,
        F_CHECK1
    } front_state_t;

    // What the front decided about one byte.
    typedef enum logic [3:0] {
        K_SYNC0_OK,
        K_SYNC0_BAD,
        K_SYNC1_OK,
        K_SYNC1_BAD,
        K_IDENT,
        K_KIND,
        K_LEN_OK,
        K_LEN_BAD,
        K_PAYLOAD,
        K_CHECK0,
        K_CHECK1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [DataW-1:0]   data;
        logic [IndexW-1:0]  index;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               payload_valid;
        logic [DataW-1:0]   payload_byte;
        logic [IndexW-1:0]  payload_index;
        logic [DataW-1:0]   packet_ident;
        logic [DataW-1:0]   packet_kind;
        logic [DataW-1:0]   payload_length;
    } result_t;

endpackage

// ===== rtl/core/serial_packet_deframer_core.sv =====
// Top level of the serial packet deframer: config registers, front, queue, back.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata[7:0] rx_byte
//  m_       out  m_tvalid/m_tready    m_tdata packet fields, m_tuser status/flag
//  cfg_     in   cfg_we               cfg_index, cfg_data
//
// One byte a cycle sustained while the queue is not full; a result is presented once
// its byte has been accepted into the queue and the back has loaded it into the
// result register, and a stalled output can hold it in the queue.
// The queue (FIFO_DEPTH entries) lets the input run while the output stalls;
// s_tready drops only when the queue is full.
// Reset clears the parser, the sums and the captured header, and loads the
// sync bytes 0x93, 0xE0 and a length limit of 128.
module serial_packet_deframer_core #(
    parameter int FIFO_DEPTH = spd_pkg::QueueDepth
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spd_pkg::DataW-1:0]      s_tdata,   // rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // payload_byte, payload_index, packet_ident, packet_kind, payload_length, pad
    output logic [spd_pkg::OutDataW-1:0]   m_tdata,
    // status, payload_valid
    output logic [spd_pkg::OutUserW-1:0]   m_tuser,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [spd_pkg::DataW-1:0]      cfg_data
);

    logic [spd_pkg::DataW-1:0] sync_first_reg;
    logic [spd_pkg::DataW-1:0] sync_second_reg;
    logic [spd_pkg::DataW-1:0] max_payload_reg;
    logic                      accept;
    logic                      pop;
    spd_pkg::item_t            front_item;
    spd_pkg::item_t            queue_item;
    spd_pkg::qstat_t           qstat;
    spd_pkg::result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= spd_pkg::SyncFirstReset;
            sync_second_reg <= spd_pkg::SyncSecondReset;
            max_payload_reg <= spd_pkg::MaxPayloadReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spd_pkg::CfgSyncFirst:  sync_first_reg  <= cfg_data;
                spd_pkg::CfgSyncSecond: sync_second_reg <= cfg_data;
                spd_pkg::CfgMaxPayload: max_payload_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    spd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .max_payload (max_payload_reg),
        .item        (front_item)
    );

    spd_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (queue_item),
        .stat      (qstat)
    );

    spd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .item      (queue_item),
        .pop       (pop),
        .res_ready (m_tready),
        .res_valid (m_tvalid),
        .res       (res)
    );

    assign m_tdata = {1'b0, res.payload_length, res.packet_kind, res.packet_ident,
                      res.payload_index, res.payload_byte};
    assign m_tuser = {res.payload_valid, res.status};

endmodule

// ===== rtl/core/spd_front.sv =====
// Front end: tracks the frame position and classifies each received byte.
module spd_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [spd_pkg::DataW-1:0]   rx_byte,
    input  logic [spd_pkg::DataW-1:0]   sync_first,
    input  logic [spd_pkg::DataW-1:0]   sync_second,
    input  logic [spd_pkg::DataW-1:0]   max_payload,
    output spd_pkg::item_t              item
);

    spd_pkg::front_state_t state_reg, state_next;
    logic [spd_pkg::IndexW-1:0] cnt_reg, cnt_next;
    logic [spd_pkg::DataW-1:0]  len_reg, len_next;
    logic [spd_pkg::DataW-1:0]  limit;
    logic [spd_pkg::DataW-1:0]  cnt_inc;

    assign limit = (max_payload > spd_pkg::PayloadMax) ? spd_pkg::PayloadMax : max_payload;
    assign cnt_inc = {1'b0, cnt_reg} + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spd_pkg::F_SYNC0;
            cnt_reg   <= '0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        item.kind  = spd_pkg::K_SYNC0_BAD;
        item.data  = rx_byte;
        item.index = cnt_reg;
        unique case (state_reg)
            spd_pkg::F_SYNC0:
            begin
                if (rx_byte == sync_first)
                begin
                    item.kind  = spd_pkg::K_SYNC0_OK;
                    state_next = spd_pkg::F_SYNC1;
                end
                else
                begin
                    item.kind = spd_pkg::K_SYNC0_BAD;
                end
            end
            spd_pkg::F_SYNC1:
            begin
                if (rx_byte == sync_second)
                begin
                    item.kind  = spd_pkg::K_SYNC1_OK;
                    state_next = spd_pkg::F_IDENT;
                end
                else
                begin
                    item.kind  = spd_pkg::K_SYNC1_BAD;
                    state_next = spd_pkg::F_SYNC0;
                end
            end
            spd_pkg::F_IDENT:
            begin
                item.kind  = spd_pkg::K_IDENT;
                state_next = spd_pkg::F_KIND;
            end
            spd_pkg::F_KIND:
            begin
                item.kind  = spd_pkg::K_KIND;
                state_next = spd_pkg::F_LEN;
            end
            spd_pkg::F_LEN:
            begin
                if (rx_byte > limit)
                begin
                    item.kind  = spd_pkg::K_LEN_BAD;
                    state_next = spd_pkg::F_SYNC0;
                end
                else
                begin
                    item.kind  = spd_pkg::K_LEN_OK;
                    len_next   = rx_byte;
                    cnt_next   = '0;
                    // zero length goes straight to the check bytes
                    state_next = (rx_byte == '0) ? spd_pkg::F_CHECK0 : spd_pkg::F_PAYLOAD;
                end
            end
            spd_pkg::F_PAYLOAD:
            begin
                item.kind = spd_pkg::K_PAYLOAD;
                cnt_next  = cnt_inc[spd_pkg::IndexW-1:0];
                if (cnt_inc == len_reg)
                begin
                    state_next = spd_pkg::F_CHECK0;
                end
            end
            spd_pkg::F_CHECK0:
            begin
                item.kind  = spd_pkg::K_CHECK0;
                state_next = spd_pkg::F_CHECK1;
            end
            spd_pkg::F_CHECK1:
            begin
                item.kind  = spd_pkg::K_CHECK1;
                state_next = spd_pkg::F_SYNC0;
            end
            default:
            begin
                state_next = spd_pkg::F_SYNC0;
            end
        endcase
    end

endmodule

// ===== rtl/core/spd_queue.sv =====
// Short queue of classified bytes between front and back.
module spd_queue #(
    parameter int DEPTH = spd_pkg::QueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spd_pkg::item_t  push_item,
    input  logic            pop,
    output spd_pkg::item_t  pop_item,
    output spd_pkg::qstat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    spd_pkg::item_t  slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;

    assign stat.full  = (count_reg == (AW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/spd_back.sv =====
// Back end: running check sums, captured header and the result register.
module spd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  spd_pkg::qstat_t qstat,
    input  spd_pkg::item_t  item,
    output logic            pop,
    input  logic            res_ready,
    output logic            res_valid,
    output spd_pkg::result_t res
);

    logic [spd_pkg::DataW-1:0] sum_low_reg, sum_low_next;
    logic [spd_pkg::DataW-1:0] sum_high_reg, sum_high_next;
    logic [spd_pkg::DataW-1:0] ident_reg, ident_next;
    logic [spd_pkg::DataW-1:0] kind_reg, kind_next;
    logic [spd_pkg::DataW-1:0] len_reg, len_next;
    logic                      fco_reg, fco_next;
    logic                      valid_reg;
    spd_pkg::result_t          res_reg, res_next;
    logic [spd_pkg::DataW-1:0] low_add;
    logic [spd_pkg::DataW-1:0] high_add;

    // result register refills while its current request is being taken
    assign pop       = !qstat.empty && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;

    assign low_add  = sum_low_reg + item.data;
    assign high_add = sum_high_reg + low_add;

    always_comb
    begin
        sum_low_next  = sum_low_reg;
        sum_high_next = sum_high_reg;
        ident_next    = ident_reg;
        kind_next     = kind_reg;
        len_next      = len_reg;
        fco_next      = fco_reg;
        res_next.status        = spd_pkg::StBusy;
        res_next.payload_valid = 1'b0;
        res_next.payload_byte  = '0;
        res_next.payload_index = '0;
        unique case (item.kind) inside
            spd_pkg::K_SYNC0_OK, spd_pkg::K_SYNC1_OK:
            begin
                res_next.status = spd_pkg::StBusy;
            end
            spd_pkg::K_SYNC0_BAD:
            begin
                res_next.status = spd_pkg::StSync0;
            end
            spd_pkg::K_SYNC1_BAD:
            begin
                res_next.status = spd_pkg::StSync1;
            end
            spd_pkg::K_IDENT:
            begin
                ident_next    = item.data;
                sum_low_next  = item.data;
                sum_high_next = item.data;
            end
            spd_pkg::K_KIND:
            begin
                kind_next     = item.data;
                sum_low_next  = low_add;
                sum_high_next = high_add;
            end
            spd_pkg::K_LEN_OK:
            begin
                len_next = item.data;
            end
            spd_pkg::K_LEN_BAD:
            begin
                res_next.status = spd_pkg::StLong;
            end
            spd_pkg::K_PAYLOAD:
            begin
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = item.data;
                res_next.payload_index = item.index;
                sum_low_next  = low_add;
                sum_high_next = high_add;
            end
            spd_pkg::K_CHECK0:
            begin
                fco_next = (item.data == sum_low_reg);
            end
            spd_pkg::K_CHECK1:
            begin
                res_next.status = (fco_reg && item.data == sum_high_reg) ?
                                  spd_pkg::StDone : spd_pkg::StCheck;
            end
            default:
            begin
                res_next.status = spd_pkg::StBusy;
            end
        endcase
        res_next.packet_ident   = ident_next;
        res_next.packet_kind    = kind_next;
        res_next.payload_length = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_low_reg  <= '0;
            sum_high_reg <= '0;
            ident_reg    <= '0;
            kind_reg     <= '0;
            len_reg      <= '0;
            fco_reg      <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                sum_low_reg  <= sum_low_next;
                sum_high_reg <= sum_high_next;
                ident_reg    <= ident_next;
                kind_reg     <= kind_next;
                len_reg      <= len_next;
                fco_reg      <= fco_next;
                valid_reg    <= 1'b1;
            end
            else if (res_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/core/spd_checker.sv =====
// Port-level checker of the deframer, bound to the top level.
module spd_port_assertions
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [spd_pkg::OutDataW-1:0]   m_tdata,
    input  logic [spd_pkg::OutUserW-1:0]   m_tuser
);

    // a stalled request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output request changed while stalled");

    // payload bytes only ever report in-progress status
    a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == spd_pkg::StBusy)
        else $error("payload byte with non-busy status");

    // payload index stays below the captured length
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> {1'b0, m_tdata[14:8]} < m_tdata[38:31])
        else $error("payload index beyond payload length");

    // captured length never exceeds the hard ceiling
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[38:31] <= spd_pkg::PayloadMax)
        else $error("payload length above ceiling");

    // with the result register empty the queue cannot be full
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no output pending");

endmodule

bind serial_packet_deframer_core spd_port_assertions u_spd_port_assertions (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
